// ===== design/hef3_pkg.sv =====
package hef3_pkg;

    // Register map (index = byte address / 4)
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BACKGROUND   = 2'd2;

    localparam int unsigned CFG_ADDR_BITS  = 4;
    localparam int unsigned FW_BITS        = 12;
    localparam int unsigned FH_BITS        = 16;
    localparam int unsigned BG_BITS        = 8;
    // input row counter runs up to one past the frame height while draining
    localparam int unsigned IN_ROW_BITS    = FH_BITS + 1;

    localparam logic [FW_BITS-1:0] FW_RESET = 12'd640;
    localparam logic [FH_BITS-1:0] FH_RESET = 16'd480;
    localparam logic [BG_BITS-1:0] BG_RESET = 8'd0;

    // which window rows / columns lie outside the frame for a result
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge_mask;

endpackage

// ===== design/hard_edge_filter_3x3_top.sv =====
// 3x3 region-boundary filter for a raster-order pixel stream, one pixel per beat
// on s_axis (tuser marks a drain beat that carries no pixel). A pixel that is not
// the background value and equals all of its in-frame neighbours leaves as the
// background value with the interior flag set; every other pixel leaves unchanged.
// The result for a pixel leaves after frame_width+1 further input beats, so after
// the last pixel of a frame send frame_width+1 drain beats to flush it; drain beats
// arriving mid-frame are swallowed without a result, and pixels arriving after
// frame end count as drain beats. The block takes one beat per clock and delivers
// one result per clock while m_axis_tready is high; the registered read of the two
// line stores puts one register stage ahead of the window and its compare, followed
// by the output register. A stalled master side backs up
// through these two stages to s_axis_tready. The line stores need no clearing
// after reset: entries not yet written only ever land at out-of-frame window
// positions. Writing frame_width or frame_height restarts the frame; program the
// registers only while the block is idle.
module hard_edge_filter_3x3_top
    import hef3_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 2048,
    parameter int PIXEL_BITS     = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input beats
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]        s_axis_tdata,  // [PIXEL_BITS-1:0] pixel_in
    input  logic                                   s_axis_tuser,  // [0] drain
    // result beats
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]        m_axis_tdata,  // [PIXEL_BITS-1:0] pixel_out
    output logic                                   m_axis_tlast,  // end_of_line
    output logic [1:0]                             m_axis_tuser,  // [0] interior_reset,
                                                                  // [1] end_of_frame
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [CFG_ADDR_BITS-1:0]               paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
    localparam int PB = PIXEL_BITS;
    localparam int DW = ((PIXEL_BITS + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FW_BITS-1:0] r_fw;
    logic [FH_BITS-1:0] r_fh;
    logic [BG_BITS-1:0] r_bg;
    logic               w_cfg_wr;
    logic               w_geom_wr;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_geom_wr = w_cfg_wr && ((paddr[3:2] == REG_FRAME_WIDTH) ||
                                    (paddr[3:2] == REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FW_RESET;
            r_fh <= FH_RESET;
            r_bg <= BG_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:  r_fw <= pwdata[FW_BITS-1:0];
                REG_FRAME_HEIGHT: r_fh <= pwdata[FH_BITS-1:0];
                REG_BACKGROUND:   r_bg <= pwdata[BG_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = 32'(r_fw);
            REG_FRAME_HEIGHT: prdata = 32'(r_fh);
            REG_BACKGROUND:   prdata = 32'(r_bg);
            default:          prdata = 32'd0;
        endcase
    end

    // effective geometry: zero acts as one, width clamps to the line store
    logic [WW-1:0]      w_width;
    logic [FH_BITS-1:0] w_height;
    logic [PB-1:0]      w_bg;

    always_comb begin
        if (r_fw == '0) begin
            w_width = WW'(1);
        end else if (32'(r_fw) > 32'(MAX_LINE_WIDTH)) begin
            w_width = WW'(MAX_LINE_WIDTH);
        end else begin
            w_width = WW'(r_fw);
        end
    end

    assign w_height = (r_fh == '0) ? FH_BITS'(1) : r_fh;
    assign w_bg     = PB'(r_bg);

    // ------------------------------------------------------------------
    // Position counters, advanced at input acceptance
    // ------------------------------------------------------------------
    logic [IN_ROW_BITS-1:0] r_in_row, n_in_row;
    logic [AW-1:0]          r_in_col, n_in_col;
    logic [FH_BITS-1:0]     r_out_row, n_out_row;
    logic [AW-1:0]          r_out_col, n_out_col;

    logic               w_s_fire;
    logic               w_complete;
    logic               w_is_drain;
    logic               w_enter;
    logic               w_ready;
    logic [AW-1:0]      w_col;
    logic [WW-1:0]      w_col_p1;
    logic               w_in_wrap;
    logic               w_out_wrap;
    logic               w_last_row;
    logic               w_eol;
    logic               w_eof;
    logic [PB-1:0]      w_px;
    t_edge_mask         w_edge;

    assign w_s_fire   = s_axis_tvalid && s_axis_tready;
    assign w_complete = r_in_row >= IN_ROW_BITS'(w_height);
    assign w_is_drain = s_axis_tuser || w_complete;
    // drain beats before the frame is complete are dropped
    assign w_enter    = w_s_fire && (!s_axis_tuser || w_complete);
    assign w_px       = w_is_drain ? '0 : s_axis_tdata[PB-1:0];

    // the window center holds a real pixel once width+1 items have entered
    assign w_ready    = (r_in_row >= IN_ROW_BITS'(2)) ||
                        ((r_in_row == IN_ROW_BITS'(1)) && (r_in_col != '0));

    assign w_col      = (WW'(r_in_col) < w_width) ? r_in_col : '0;
    assign w_col_p1   = WW'(w_col) + WW'(1);
    assign w_in_wrap  = w_col_p1 >= w_width;

    assign w_out_wrap = (WW'(r_out_col) + WW'(1)) >= w_width;
    assign w_last_row = (IN_ROW_BITS'(r_out_row) + IN_ROW_BITS'(1)) >=
                        IN_ROW_BITS'(w_height);
    assign w_eol      = w_out_wrap;
    assign w_eof      = w_out_wrap && w_last_row;

    assign w_edge.top    = (r_out_row == '0);
    assign w_edge.bottom = w_last_row;
    assign w_edge.left   = (r_out_col == '0);
    assign w_edge.right  = w_out_wrap;

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (w_geom_wr) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
        end else if (w_enter) begin
            if (w_in_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_BITS'(1);
            end else begin
                n_in_col = AW'(w_col_p1);
            end
            if (w_ready) begin
                if (w_eof) begin
                    // frame done: next pixel starts a new frame
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end else if (w_out_wrap) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + FH_BITS'(1);
                end else begin
                    n_out_col = r_out_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: item waiting for its line-store read data
    // ------------------------------------------------------------------
    logic          r_a_valid;
    logic          r_a_res;
    logic [PB-1:0] r_a_px;
    logic [AW-1:0] r_a_col;
    logic          r_a_eol;
    logic          r_a_eof;
    t_edge_mask    r_a_edge;
    logic          w_a_go;

    logic          r_o_valid;

    // advance when no result is made or the output register frees up
    assign w_a_go        = r_a_valid && (!r_a_res || !r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || w_a_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_enter) begin
            r_a_valid <= 1'b1;
        end else if (w_a_go) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enter) begin
            r_a_res  <= w_ready;
            r_a_px   <= w_px;
            r_a_col  <= w_col;
            r_a_eol  <= w_eol;
            r_a_eof  <= w_eof;
            r_a_edge <= w_edge;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: read on entry, write when stage A advances.
    // Forward the write when both hit the same column in one cycle.
    // ------------------------------------------------------------------
    logic [PB-1:0] mem_upper [MAX_LINE_WIDTH];
    logic [PB-1:0] mem_middle[MAX_LINE_WIDTH];
    logic [PB-1:0] r_up_rd;
    logic [PB-1:0] r_mid_rd;
    logic          w_same_col;

    assign w_same_col = w_a_go && (r_a_col == w_col);

    always_ff @(posedge i_clk) begin
        if (w_a_go) begin
            mem_upper[r_a_col] <= r_mid_rd;
        end
        if (w_enter) begin
            r_up_rd <= w_same_col ? r_mid_rd : mem_upper[w_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_go) begin
            mem_middle[r_a_col] <= r_a_px;
        end
        if (w_enter) begin
            r_mid_rd <= w_same_col ? r_a_px : mem_middle[w_col];
        end
    end

    // ------------------------------------------------------------------
    // Window shift and neighbour compare
    // ------------------------------------------------------------------
    logic [PB-1:0] r_win[9];
    logic [PB-1:0] n_win[9];
    logic          w_interior;
    logic          w_skip;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3+0] = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = r_up_rd;
        n_win[5] = r_mid_rd;
        n_win[8] = r_a_px;
    end

    always_comb begin
        w_interior = (n_win[4] != w_bg);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // skip the center and any neighbour outside the frame
                w_skip = ((r == 1) && (c == 1)) ||
                         ((r == 0) && r_a_edge.top) || ((r == 2) && r_a_edge.bottom) ||
                         ((c == 0) && r_a_edge.left) || ((c == 2) && r_a_edge.right);
                if (!w_skip && (n_win[r*3+c] != n_win[4])) begin
                    w_interior = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_a_go) begin
            r_win <= n_win;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PB-1:0] r_o_px;
    logic          r_o_int;
    logic          r_o_eol;
    logic          r_o_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_a_go && r_a_res) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_go && r_a_res) begin
            r_o_px  <= w_interior ? w_bg : n_win[4];
            r_o_int <= w_interior;
            r_o_eol <= r_a_eol;
            r_o_eof <= r_a_eof;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = DW'(r_o_px);
    assign m_axis_tlast  = r_o_eol;
    assign m_axis_tuser  = {r_o_eof, r_o_int};

`ifndef SYNTHESIS
    a_eof_needs_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_eof |-> r_o_eol)
        else $error("end of frame without end of line");

    a_interior_is_bg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_int |-> (r_o_px == w_bg))
        else $error("interior pixel not replaced by background");

    a_out_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_out_col) < w_width)
        else $error("output column beyond frame width");

    a_in_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (18'(r_in_row) <= (18'(w_height) + 18'd2)))
        else $error("input row counter ran past the drain window");

    a_stall_holds_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_a_go |=> r_a_valid && $stable(r_a_col) && $stable(r_mid_rd))
        else $error("stage A lost its item during a stall");
`endif

endmodule
